[hw/rtl/group_prefix_rp_table_defines.svh]
// Assertion macros shared by the RP table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GROUP_PREFIX_RP_TABLE_DEFINES_SVH
`define GROUP_PREFIX_RP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GPRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GPRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/gprt_pkg.sv]
// Types, constants and codes for the group prefix RP table.
// No dependencies; used by every module of the block.
`default_nettype none

package gprt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = 128;
   localparam int HALF_W = 64;
   localparam int LEN_W  = 8;

   localparam logic [LEN_W-1:0] MAX_LEN = 8'd128;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DEL    = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_RSVD   = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_WRITE = 2'd2
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] group;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] rp;
   } entry_type;

   typedef struct packed {
      op_kind_type       op;
      logic [ADDR_W-1:0] group;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] rp;
   } request_type;

   typedef struct packed {
      logic             set_valid;
      logic             clr_valid;
      logic             wr_key;
      logic             wr_rp;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } wr_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/gprt_cmp.sv]
// Prefix compare unit: do two 128-bit addresses agree on their leading bits.
// Depends on gprt_pkg.
`default_nettype none

module gprt_cmp (
   input  logic [gprt_pkg::ADDR_W-1:0] a,
   input  logic [gprt_pkg::ADDR_W-1:0] b,
   input  logic [gprt_pkg::LEN_W-1:0]  len,
   output logic                        hit
);

   logic [gprt_pkg::ADDR_W-1:0] mask;

   // A length of 128 shifts every one out, so the mask covers the whole word.
   always_comb begin
      mask = ~({gprt_pkg::ADDR_W{1'b1}} >> len);
      hit  = ((a ^ b) & mask) == '0;
   end

endmodule

`default_nettype wire

[hw/rtl/gprt_store.sv]
// Slot storage: valid flops plus group, length and RP memories with one
// registered read port and one write port. Depends on gprt_pkg.
`default_nettype none

module gprt_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [gprt_pkg::IDX_W-1:0]   rd_addr,
   input  gprt_pkg::wr_cmd_type         wr_cmd,
   output logic                         rd_valid,
   output gprt_pkg::entry_type          rd_entry
);

   logic [gprt_pkg::ADDR_W-1:0] group_mem [gprt_pkg::TABLE_ENTRIES];
   logic [gprt_pkg::LEN_W-1:0]  len_mem   [gprt_pkg::TABLE_ENTRIES];
   logic [gprt_pkg::ADDR_W-1:0] rp_mem    [gprt_pkg::TABLE_ENTRIES];

   logic [gprt_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                               rd_valid_ff;
   logic [gprt_pkg::ADDR_W-1:0]        rd_group_ff;
   logic [gprt_pkg::LEN_W-1:0]         rd_len_ff;
   logic [gprt_pkg::ADDR_W-1:0]        rd_rp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_cmd.set_valid) begin
         valid_in[wr_cmd.addr] = 1'b1;
      end
      if (wr_cmd.clr_valid) begin
         valid_in[wr_cmd.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.wr_key) begin
         group_mem[wr_cmd.addr] <= wr_cmd.data.group;
         len_mem[wr_cmd.addr]   <= wr_cmd.data.len;
      end
      if (wr_cmd.wr_rp) begin
         rp_mem[wr_cmd.addr] <= wr_cmd.data.rp;
      end
      if (rd_en) begin
         rd_group_ff <= group_mem[rd_addr];
         rd_len_ff   <= len_mem[rd_addr];
         rd_rp_ff    <= rp_mem[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_entry = '{group: rd_group_ff, len: rd_len_ff, rp: rd_rp_ff};

endmodule

`default_nettype wire

[hw/rtl/gprt_seq.sv]
// Scan sequencer: walks the slots once per request through the shared
// prefix compare unit, then writes back and forms the response.
// Depends on gprt_pkg, gprt_cmp and the assertion macro header.
`default_nettype none
`include "group_prefix_rp_table_defines.svh"

module gprt_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  gprt_pkg::request_type         req,
   input  logic                          rd_valid,
   input  gprt_pkg::entry_type           rd_entry,
   output logic                          busy,
   output logic                          rd_en,
   output logic [gprt_pkg::IDX_W-1:0]    rd_addr,
   output gprt_pkg::wr_cmd_type          wr_cmd,
   output logic                          rsp_valid,
   output gprt_pkg::status_type          rsp_status,
   output logic [gprt_pkg::ADDR_W-1:0]   rsp_found_rp,
   output logic [gprt_pkg::LEN_W-1:0]    rsp_match_len
);

   localparam logic [gprt_pkg::CNT_W-1:0] CNT_LAST = gprt_pkg::CNT_W'(gprt_pkg::TABLE_ENTRIES);

   gprt_pkg::state_type         state_ff, state_in;
   logic [gprt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        hit_ff, hit_in;
   logic [gprt_pkg::IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic                        free_ff, free_in;
   logic [gprt_pkg::IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic                        best_ff, best_in;
   logic [gprt_pkg::LEN_W-1:0]  best_len_ff, best_len_in;
   logic [gprt_pkg::ADDR_W-1:0] best_rp_ff, best_rp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   gprt_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [gprt_pkg::ADDR_W-1:0] rsp_rp_ff, rsp_rp_in;
   logic [gprt_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic                        eval_en;
   logic [gprt_pkg::CNT_W-1:0]  eval_cnt;
   logic [gprt_pkg::IDX_W-1:0]  eval_idx;
   logic                        pfx_hit;
   logic                        key_eq;
   logic                        hit_cand;
   logic                        free_cand;
   logic                        best_cand;

   // Every compare runs at the stored length: for add and delete the stored
   // length must equal the request length anyway.
   gprt_cmp u_cmp (
      .a   (req.group),
      .b   (rd_entry.group),
      .len (rd_entry.len),
      .hit (pfx_hit)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gprt_pkg::S_IDLE: begin
            if (accept) begin
               state_in = gprt_pkg::S_SCAN;
            end
         end
         gprt_pkg::S_SCAN: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = gprt_pkg::S_WRITE;
            end
         end
         gprt_pkg::S_WRITE: begin
            state_in = gprt_pkg::S_IDLE;
         end
         default: begin
            state_in = gprt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      rd_en    = 1'b0;
      eval_en  = 1'b0;
      rd_addr  = cnt_ff[gprt_pkg::IDX_W-1:0];
      eval_cnt = cnt_ff - gprt_pkg::CNT_W'(1);
      eval_idx = eval_cnt[gprt_pkg::IDX_W-1:0];
      wr_cmd   = '0;
      wr_cmd.data = '{group: req.group, len: req.len, rp: req.rp};
      case (state_ff)
         gprt_pkg::S_IDLE: begin
            busy = 1'b0;
         end
         gprt_pkg::S_SCAN: begin
            busy    = 1'b1;
            rd_en   = cnt_ff != CNT_LAST;
            eval_en = cnt_ff != '0;
         end
         gprt_pkg::S_WRITE: begin
            busy = 1'b1;
            case (req.op)
               gprt_pkg::OP_ADD: begin
                  if (hit_ff) begin
                     wr_cmd.wr_rp = 1'b1;
                     wr_cmd.addr  = hit_idx_ff;
                  end else if (free_ff) begin
                     wr_cmd.set_valid = 1'b1;
                     wr_cmd.wr_key    = 1'b1;
                     wr_cmd.wr_rp     = 1'b1;
                     wr_cmd.addr      = free_idx_ff;
                  end
               end
               gprt_pkg::OP_DEL: begin
                  if (hit_ff) begin
                     wr_cmd.clr_valid = 1'b1;
                     wr_cmd.addr      = hit_idx_ff;
                  end
               end
               default: begin
                  wr_cmd.addr = '0;
               end
            endcase
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_comb begin
      key_eq    = pfx_hit && (rd_entry.len == req.len);
      hit_cand  = eval_en && rd_valid && !hit_ff && key_eq &&
                  ((req.op == gprt_pkg::OP_ADD) ||
                   ((req.op == gprt_pkg::OP_DEL) && (rd_entry.rp == req.rp)));
      free_cand = eval_en && !rd_valid && !free_ff && (req.op == gprt_pkg::OP_ADD);
      best_cand = eval_en && rd_valid && pfx_hit && (req.op == gprt_pkg::OP_LOOKUP) &&
                  (!best_ff || (rd_entry.len > best_len_ff));

      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_len_in   = best_len_ff;
      best_rp_in    = best_rp_ff;
      rsp_valid_in  = state_ff == gprt_pkg::S_WRITE;
      rsp_status_in = rsp_status_ff;
      rsp_rp_in     = rsp_rp_ff;
      rsp_len_in    = rsp_len_ff;

      if ((state_ff == gprt_pkg::S_IDLE) && accept) begin
         cnt_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
         best_in = 1'b0;
      end

      if (state_ff == gprt_pkg::S_SCAN) begin
         cnt_in = cnt_ff + gprt_pkg::CNT_W'(1);
      end

      if (hit_cand) begin
         hit_in     = 1'b1;
         hit_idx_in = eval_idx;
      end
      if (free_cand) begin
         free_in     = 1'b1;
         free_idx_in = eval_idx;
      end
      if (best_cand) begin
         best_in     = 1'b1;
         best_len_in = rd_entry.len;
         best_rp_in  = rd_entry.rp;
      end

      if (state_ff == gprt_pkg::S_WRITE) begin
         rsp_rp_in  = '0;
         rsp_len_in = '0;
         case (req.op)
            gprt_pkg::OP_ADD: begin
               rsp_status_in = (hit_ff || free_ff) ? gprt_pkg::ST_OK : gprt_pkg::ST_FULL;
            end
            gprt_pkg::OP_DEL: begin
               rsp_status_in = hit_ff ? gprt_pkg::ST_OK : gprt_pkg::ST_NOT_FOUND;
            end
            gprt_pkg::OP_LOOKUP: begin
               if (best_ff) begin
                  rsp_status_in = gprt_pkg::ST_OK;
                  rsp_rp_in     = best_rp_ff;
                  rsp_len_in    = best_len_ff;
               end else begin
                  rsp_status_in = gprt_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = gprt_pkg::ST_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gprt_pkg::S_IDLE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         best_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      best_len_ff   <= best_len_in;
      best_rp_ff    <= best_rp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rp_ff     <= rsp_rp_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_rp  = rsp_rp_ff;
   assign rsp_match_len = rsp_len_ff;

   `GPRT_ASSERT_NEXT(a_write_gives_rsp, clock, reset, state_ff == gprt_pkg::S_WRITE, rsp_valid_ff, "write-back cycle not followed by a response")
   `GPRT_ASSERT_NOW(a_rsp_only_after_write, clock, reset, rsp_valid_ff, (state_ff == gprt_pkg::S_IDLE) && $past(state_ff == gprt_pkg::S_WRITE), "response strobe without a write-back cycle")
   `GPRT_ASSERT_NOW(a_full_only_on_add, clock, reset, rsp_valid_ff && (rsp_status_ff == gprt_pkg::ST_FULL), (req.op == gprt_pkg::OP_ADD) && !hit_ff && !free_ff, "table full reported with a slot available")
   `GPRT_ASSERT_NOW(a_len_only_on_lookup, clock, reset, rsp_valid_ff && (rsp_len_ff != '0), (rsp_status_ff == gprt_pkg::ST_OK) && (req.op == gprt_pkg::OP_LOOKUP), "match length given outside a successful lookup")
   `GPRT_ASSERT_NOW(a_hit_needs_key_op, clock, reset, (state_ff == gprt_pkg::S_SCAN) && hit_ff, (req.op == gprt_pkg::OP_ADD) || (req.op == gprt_pkg::OP_DEL), "key hit recorded for a lookup or reserved request")

endmodule

`default_nettype wire

[hw/rtl/group_prefix_rp_table.sv]
// Top level of the static rendezvous-point table with longest prefix match.
// Depends on gprt_pkg, gprt_store and gprt_seq.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_*            taken at a clock edge with start high, busy low
//   response  rsp_valid, rsp_*              one-cycle strobe, always taken
//
// A request keeps the block busy through the scan and the write-back: the slot
// memory has a single read port, so the scan reads one slot per cycle, the
// compare of the last slot follows its registered read, then write-back runs.
// The response strobe comes in the cycle after write-back, and a new request
// can be taken in that same cycle. The receiver cannot stall the block.
// Synchronous reset clears all slot valid bits at once; no clearing pass runs.
`default_nettype none

module group_prefix_rp_table (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [gprt_pkg::HALF_W-1:0]   req_group_addr_hi,
   input  logic [gprt_pkg::HALF_W-1:0]   req_group_addr_lo,
   input  logic [gprt_pkg::LEN_W-1:0]    req_prefix_len,
   input  logic [gprt_pkg::HALF_W-1:0]   req_rp_addr_hi,
   input  logic [gprt_pkg::HALF_W-1:0]   req_rp_addr_lo,

   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [gprt_pkg::HALF_W-1:0]   rsp_found_rp_hi,
   output logic [gprt_pkg::HALF_W-1:0]   rsp_found_rp_lo,
   output logic [gprt_pkg::LEN_W-1:0]    rsp_match_len
);

   // The request is held for the whole scan, since every slot is compared
   // against it and the write-back takes its fields.
   gprt_pkg::request_type       req_ff, req_in;
   logic                        accept;
   logic [gprt_pkg::LEN_W-1:0]  len_clamped;

   logic                        seq_busy;
   logic                        rd_en;
   logic [gprt_pkg::IDX_W-1:0]  rd_addr;
   gprt_pkg::wr_cmd_type        wr_cmd;
   logic                        rd_valid;
   gprt_pkg::entry_type         rd_entry;
   gprt_pkg::status_type        seq_status;
   logic [gprt_pkg::ADDR_W-1:0] seq_found_rp;

   assign accept = start && !seq_busy;

   // Prefix lengths beyond the address width mean a full-width match.
   always_comb begin
      len_clamped = (req_prefix_len > gprt_pkg::MAX_LEN) ? gprt_pkg::MAX_LEN : req_prefix_len;
      req_in = req_ff;
      if (accept) begin
         req_in.op    = gprt_pkg::op_kind_type'(req_type);
         req_in.group = {req_group_addr_hi, req_group_addr_lo};
         req_in.len   = len_clamped;
         req_in.rp    = {req_rp_addr_hi, req_rp_addr_lo};
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   gprt_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_cmd   (wr_cmd),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry)
   );

   gprt_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_ff),
      .rd_valid      (rd_valid),
      .rd_entry      (rd_entry),
      .busy          (seq_busy),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .wr_cmd        (wr_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_status    (seq_status),
      .rsp_found_rp  (seq_found_rp),
      .rsp_match_len (rsp_match_len)
   );

   assign busy            = seq_busy;
   assign rsp_status      = seq_status;
   assign rsp_found_rp_hi = seq_found_rp[gprt_pkg::ADDR_W-1:gprt_pkg::HALF_W];
   assign rsp_found_rp_lo = seq_found_rp[gprt_pkg::HALF_W-1:0];

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the group prefix RP table (add, delete, longest prefix lookup).
// Depends on gprt_pkg and the group_prefix_rp_table RTL; it needs no other file.
`timescale 1ns / 100ps

module testbench;

   import gprt_pkg::*;

   // Watchdog for the whole run: about 900 requests, each with its scan and
   // write-back, a sender gap and at times a drain, stay far below this
   // limit.
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_COUNT = 850;
   localparam int unsigned POOL_SIZE = 24;
   localparam int unsigned TAIL_CYCLES = 3 * TABLE_ENTRIES;

   // One request as the sender sees it. The gap is the number of idle cycles
   // placed in front of it, and a request marked drain is held back until
   // every answer already owed by the block has come out.
   typedef struct {
      op_kind_type       op;
      logic [ADDR_W-1:0] group;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] rp;
      int unsigned       gap;
      bit                drain;
   } rp_request_t;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] rp;
      logic [LEN_W-1:0]  len;
   } rp_answer_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_type = OP_ADD;
   logic [HALF_W-1:0]   req_group_addr_hi = '0;
   logic [HALF_W-1:0]   req_group_addr_lo = '0;
   logic [LEN_W-1:0]    req_prefix_len = '0;
   logic [HALF_W-1:0]   req_rp_addr_hi = '0;
   logic [HALF_W-1:0]   req_rp_addr_lo = '0;

   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [HALF_W-1:0]   rsp_found_rp_hi;
   logic [HALF_W-1:0]   rsp_found_rp_lo;
   logic [LEN_W-1:0]    rsp_match_len;

   // Requests waiting to be sent, and the answers the block still owes, oldest
   // first.
   rp_request_t queued_requests[$];
   rp_answer_t  table_answers[$];
   rp_request_t current_req;

   // The testbench's own copy of the slot table.
   bit                shadow_valid [TABLE_ENTRIES];
   logic [ADDR_W-1:0] shadow_group [TABLE_ENTRIES];
   logic [LEN_W-1:0]  shadow_len   [TABLE_ENTRIES];
   logic [ADDR_W-1:0] shadow_rp    [TABLE_ENTRIES];

   int unsigned n_accepted = 0;
   int unsigned n_total = 0;
   int unsigned n_fail = 0;
   int unsigned gap_left = 0;
   int unsigned cycle_count = 0;
   rp_answer_t  owed;

   group_prefix_rp_table i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_group_addr_hi (req_group_addr_hi),
      .req_group_addr_lo (req_group_addr_lo),
      .req_prefix_len    (req_prefix_len),
      .req_rp_addr_hi    (req_rp_addr_hi),
      .req_rp_addr_lo    (req_rp_addr_lo),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found_rp_hi   (rsp_found_rp_hi),
      .rsp_found_rp_lo   (rsp_found_rp_lo),
      .rsp_match_len     (rsp_match_len)
   );

   always #6 clock = ~clock;

   // Mask of the leading len bits of a 128-bit address; len is 0 to 128.
   function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
      if (len == 0) return '0;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   function automatic logic [HALF_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_request(input op_kind_type op, input logic [ADDR_W-1:0] group,
                                         input logic [LEN_W-1:0] len,
                                         input logic [ADDR_W-1:0] rp,
                                         input int unsigned gap, input bit drain);
      rp_request_t r;
      r.op = op;
      r.group = group;
      r.len = len;
      r.rp = rp;
      r.gap = gap;
      r.drain = drain;
      queued_requests.push_back(r);
   endfunction

   // Applies one accepted request to the shadow table and records the answer
   // the block has to give for it.
   function automatic void table_step(input rp_request_t r);
      int          hit;
      int          free_slot;
      int unsigned plen;
      int unsigned best;
      bit          found;
      rp_answer_t  a;
      a.status = ST_NOT_FOUND;
      a.rp = '0;
      a.len = '0;
      plen = (r.len > MAX_LEN) ? int'(MAX_LEN) : int'(r.len);
      hit = -1;
      free_slot = -1;
      found = 1'b0;
      best = 0;
      case (r.op)
         OP_ADD: begin
            // An entry of the same length covering the group only gets a new
            // RP; otherwise the lowest free slot takes the whole request.
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!shadow_valid[i]) begin
                  if (free_slot < 0) free_slot = i;
               end else if (hit < 0 && shadow_len[i] == plen &&
                            ((r.group ^ shadow_group[i]) & prefix_mask(plen)) == '0) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               shadow_rp[hit] = r.rp;
               a.status = ST_OK;
            end else if (free_slot >= 0) begin
               shadow_valid[free_slot] = 1'b1;
               shadow_group[free_slot] = r.group;
               shadow_len[free_slot] = LEN_W'(plen);
               shadow_rp[free_slot] = r.rp;
               a.status = ST_OK;
            end else begin
               a.status = ST_FULL;
            end
         end
         OP_DEL: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (hit < 0 && shadow_valid[i] && shadow_rp[i] == r.rp &&
                   shadow_len[i] == plen &&
                   ((r.group ^ shadow_group[i]) & prefix_mask(plen)) == '0) begin
                  shadow_valid[i] = 1'b0;
                  hit = i;
                  a.status = ST_OK;
               end
            end
         end
         OP_LOOKUP: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (shadow_valid[i] && (!found || shadow_len[i] > best) &&
                   ((r.group ^ shadow_group[i]) & prefix_mask(shadow_len[i])) == '0) begin
                  found = 1'b1;
                  best = shadow_len[i];
                  a.rp = shadow_rp[i];
               end
            end
            if (found) begin
               a.status = ST_OK;
               a.len = LEN_W'(best);
            end
         end
         default: begin
            // The reserved code leaves the table alone and reports not found.
         end
      endcase
      table_answers.push_back(a);
   endfunction

   function automatic void compare_field(input string name, input logic [HALF_W-1:0] want,
                                         input logic [HALF_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         n_fail++;
      end
   endfunction

   // Driver. A request stays on the ports while busy is high and is taken at
   // the first edge with start high and busy low. At that edge the answer is
   // predicted, and the next request goes out at once unless it carries a gap
   // or must wait for the block to drain.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            table_step(current_req);
            n_accepted++;
            if (queued_requests.size() != 0) gap_left = queued_requests[0].gap;
         end
         if (start && busy) begin
            // Still waiting for the block to take the current request.
         end else if (gap_left != 0 && (start || busy)) begin
            // A gap only counts once the block is free, so it shows as idle time.
            start <= 1'b0;
         end else if (gap_left > 1) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_requests.size() != 0 &&
                      !(queued_requests[0].drain && table_answers.size() != 0)) begin
            gap_left = 0;
            current_req = queued_requests.pop_front();
            start <= 1'b1;
            req_type <= current_req.op;
            req_group_addr_hi <= current_req.group[ADDR_W-1:HALF_W];
            req_group_addr_lo <= current_req.group[HALF_W-1:0];
            req_prefix_len <= current_req.len;
            req_rp_addr_hi <= current_req.rp[ADDR_W-1:HALF_W];
            req_rp_addr_lo <= current_req.rp[HALF_W-1:0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Every strobe is one answer and is matched against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (table_answers.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_status);
            n_fail++;
         end else begin
            owed = table_answers.pop_front();
            compare_field("status", HALF_W'(owed.status), HALF_W'(rsp_status));
            compare_field("found_rp_hi", owed.rp[ADDR_W-1:HALF_W], rsp_found_rp_hi);
            compare_field("found_rp_lo", owed.rp[HALF_W-1:0], rsp_found_rp_lo);
            compare_field("match_len", HALF_W'(owed.len), HALF_W'(rsp_match_len));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] bases [4];
      logic [ADDR_W-1:0] pool_group [POOL_SIZE];
      logic [LEN_W-1:0]  pool_len   [POOL_SIZE];
      logic [ADDR_W-1:0] pool_rp    [POOL_SIZE];
      int unsigned       pool_count;
      int unsigned       pick;
      int unsigned       plen;
      int unsigned       gap;
      int unsigned       roll;
      bit                drain;
      logic [ADDR_W-1:0] group;
      logic [ADDR_W-1:0] rp;
      logic [ADDR_W-1:0] mask;
      logic [LEN_W-1:0]  raw_len;

      // Directed part. An empty table answers not found to everything, and the
      // reserved code does the same with every field at its maximum.
      queue_request(OP_LOOKUP, '0, '0, '0, 0, 0);
      queue_request(OP_DEL, '0, '0, '0, 0, 0);
      queue_request(OP_RSVD, '1, '1, '1, 0, 0);
      // A zero-length prefix matches any group.
      rp = {rand64(), rand64()};
      queue_request(OP_ADD, '0, '0, rp, 0, 0);
      queue_request(OP_LOOKUP, {rand64(), rand64()}, '1, '0, 0, 0);
      // A full-length entry, then an add whose length above 128 is clamped and
      // so only updates the RP of that entry.
      queue_request(OP_ADD, '1, MAX_LEN, '1, 0, 0);
      rp = {rand64(), rand64()};
      queue_request(OP_ADD, '1, 8'd200, rp, 0, 0);
      queue_request(OP_LOOKUP, '1, '0, '0, 0, 0);
      // Delete with a wrong RP misses, then a clamped delete with the right
      // one frees the slot.
      queue_request(OP_DEL, '1, MAX_LEN, '1, 0, 0);
      queue_request(OP_DEL, '1, 8'd255, rp, 0, 0);
      queue_request(OP_ADD, {64'hFFFF_FFFF_FFFF_FFFF, rand64()}, 8'd64,
                    {rand64(), rand64()}, 0, 0);
      // Fill every slot with distinct lengths, then one more add is refused.
      for (int k = 0; k < TABLE_ENTRIES - 2; k++) begin
         queue_request(OP_ADD, {rand64(), rand64()}, LEN_W'(100 + k),
                       {rand64(), rand64()}, 0, 0);
      end
      queue_request(OP_ADD, {rand64(), rand64()}, 8'd99, {rand64(), rand64()}, 0, 0);

      // Random part. Groups grow from a few base addresses so that prefixes
      // nest and the longest match has real competition. A pool of earlier
      // adds feeds updates, deletes that hit, and lookups under live prefixes.
      for (int b = 0; b < 4; b++) bases[b] = {rand64(), rand64()};
      pool_count = 0;
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         // Idle bursts come in alternating stretches and stop near the end.
         gap = 0;
         if (((i / 64) % 2) == 0 && i < RANDOM_COUNT - 120 && $urandom_range(99) < 30)
            gap = $urandom_range(18, 1);
         drain = (i == 0) || ($urandom_range(59) == 0);
         roll = $urandom_range(99);
         if (roll < 36) begin
            if (pool_count != 0 && $urandom_range(99) < 35) begin
               // Same length and prefix as a pool entry, new RP: an update.
               pick = $urandom_range(pool_count - 1);
               plen = (pool_len[pick] > MAX_LEN) ? int'(MAX_LEN) : int'(pool_len[pick]);
               mask = prefix_mask(plen);
               group = (pool_group[pick] & mask) | ({rand64(), rand64()} & ~mask);
               raw_len = pool_len[pick];
               rp = {rand64(), rand64()};
               pool_rp[pick] = rp;
            end else begin
               roll = $urandom_range(99);
               if (roll < 8) plen = 0;
               else if (roll < 20) plen = ADDR_W;
               else plen = $urandom_range(ADDR_W - 1, 1);
               mask = prefix_mask(plen);
               group = (bases[$urandom_range(3)] & mask) | ({rand64(), rand64()} & ~mask);
               raw_len = (plen == ADDR_W && $urandom_range(1) == 1) ?
                         LEN_W'($urandom_range(255, 129)) : LEN_W'(plen);
               rp = {rand64(), rand64()};
               pick = (pool_count < POOL_SIZE) ? pool_count : $urandom_range(POOL_SIZE - 1);
               if (pool_count < POOL_SIZE) pool_count++;
               pool_group[pick] = group;
               pool_len[pick] = raw_len;
               pool_rp[pick] = rp;
            end
            queue_request(OP_ADD, group, raw_len, rp, gap, drain);
         end else if (roll < 66) begin
            if (pool_count != 0 && $urandom_range(99) < 85) begin
               pick = $urandom_range(pool_count - 1);
               plen = (pool_len[pick] > MAX_LEN) ? int'(MAX_LEN) : int'(pool_len[pick]);
               mask = prefix_mask(plen);
               group = (pool_group[pick] & mask) | ({rand64(), rand64()} & ~mask);
               raw_len = pool_len[pick];
               rp = ($urandom_range(9) == 0) ? {rand64(), rand64()} : pool_rp[pick];
               pool_count--;
               pool_group[pick] = pool_group[pool_count];
               pool_len[pick] = pool_len[pool_count];
               pool_rp[pick] = pool_rp[pool_count];
            end else begin
               group = {rand64(), rand64()};
               raw_len = LEN_W'($urandom_range(255));
               rp = {rand64(), rand64()};
            end
            queue_request(OP_DEL, group, raw_len, rp, gap, drain);
         end else if (roll < 95) begin
            if ($urandom_range(99) < 85) begin
               plen = $urandom_range(ADDR_W);
               mask = prefix_mask(plen);
               group = (bases[$urandom_range(3)] & mask) | ({rand64(), rand64()} & ~mask);
            end else begin
               group = {rand64(), rand64()};
            end
            // Length and RP are ignored by a lookup; random values check that.
            queue_request(OP_LOOKUP, group, LEN_W'($urandom_range(255)),
                          {rand64(), rand64()}, gap, drain);
         end else begin
            queue_request(OP_RSVD, {rand64(), rand64()}, LEN_W'($urandom_range(255)),
                          {rand64(), rand64()}, gap, drain);
         end
      end
      n_total = queued_requests.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != n_total || table_answers.size() != 0) @(posedge clock);
      // Let a stray late strobe show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_fail == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gprt_pkg.sv
hw/rtl/gprt_cmp.sv
hw/rtl/gprt_store.sv
hw/rtl/gprt_seq.sv
hw/rtl/group_prefix_rp_table.sv
verif/testbench.sv
